// ===== design/rsw_pkg.sv =====
// ----------------------------------------------------------------------------
// rsw_pkg: shared types and constants for the register window
// Beat layouts, operation codes and default sizes used by every module.
// ----------------------------------------------------------------------------
package rsw_pkg;

    localparam int RX_BYTES_DEF    = 32;
    localparam int ORDER_BYTES_DEF = 2;
    localparam int FRAME_BYTES_DEF = 16;

    localparam logic [7:0] RX_RESET_VALUE = 8'd6;

    // Register numbers that carry transmit data.
    localparam logic [7:0] REG_ORDER = 8'd0;
    localparam logic [7:0] REG_FRAME = 8'd1;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        MODE_TX_WRITE  = 2'd0,
        MODE_RX_READ   = 2'd1,
        MODE_BUS_BYTE  = 2'd2,
        MODE_COLLISION = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic       is_read;
        logic       is_data;
        logic [7:0] bus_byte;
        logic [4:0] local_index;
        logic [7:0] local_value;
    } item_t;

    typedef struct packed {
        logic [7:0] send_byte;
        logic       send_valid;
        logic       stored;
        logic [7:0] selected_register;
        logic [7:0] local_read_byte;
    } result_t;

    // Write request into the receive store.
    typedef struct packed {
        logic       en;
        logic [5:0] pos;
        logic [7:0] data;
    } rx_wr_t;

    // Write request into the transmit store.
    typedef struct packed {
        logic       en;
        logic [4:0] index;
        logic [7:0] data;
    } tx_wr_t;

endpackage

// ===== design/rsw_rx_store.sv =====
// ----------------------------------------------------------------------------
// rsw_rx_store: receive byte store
// Holds the bytes written by the bus master; read back from the local side.
// ----------------------------------------------------------------------------
module rsw_rx_store
    import rsw_pkg::*;
#(
    parameter int RX_BYTES = RX_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  rx_wr_t     wr,
    input  logic [4:0] rd_index,
    output logic [7:0] rd_data
);

    localparam int         RX_IW  = (RX_BYTES > 1) ? $clog2(RX_BYTES) : 1;
    localparam logic [5:0] RX_LEN = 6'(RX_BYTES);

    logic [7:0] store_reg [RX_BYTES];
    logic       rd_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RX_BYTES; i++)
            begin
                store_reg[i] <= RX_RESET_VALUE;
            end
        end
        else if (wr.en)
        begin
            store_reg[wr.pos[RX_IW-1:0]] <= wr.data;
        end
    end

    assign rd_hit  = ({1'b0, rd_index} < RX_LEN);
    assign rd_data = rd_hit ? store_reg[rd_index[RX_IW-1:0]] : 8'd0;

endmodule

// ===== design/rsw_tx_store.sv =====
// ----------------------------------------------------------------------------
// rsw_tx_store: transmit byte store
// Order word followed by the acquisition frame, loaded from the local side.
// ----------------------------------------------------------------------------
module rsw_tx_store
    import rsw_pkg::*;
#(
    parameter int ORDER_BYTES = ORDER_BYTES_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tx_wr_t     wr,
    input  logic [7:0] rd_reg,
    input  logic [5:0] rd_pos,
    output logic [7:0] rd_data
);

    localparam int         TX_BYTES  = ORDER_BYTES + FRAME_BYTES;
    localparam int         TX_IW     = (TX_BYTES > 1) ? $clog2(TX_BYTES) : 1;
    localparam logic [6:0] TX_LEN    = 7'(TX_BYTES);
    localparam logic [6:0] ORDER_OFS = 7'(ORDER_BYTES);
    localparam logic [5:0] ORDER_LEN = 6'(ORDER_BYTES);
    localparam logic [5:0] FRAME_LEN = 6'(FRAME_BYTES);

    logic [7:0] store_reg [TX_BYTES];
    logic [6:0] wr_addr;
    logic [6:0] rd_addr;
    logic       rd_hit;

    assign wr_addr = {2'b00, wr.index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TX_BYTES; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else if (wr.en && (wr_addr < TX_LEN))
        begin
            store_reg[wr_addr[TX_IW-1:0]] <= wr.data;
        end
    end

    // The frame register starts right after the order word.
    assign rd_addr = (rd_reg == REG_FRAME) ? (ORDER_OFS + {1'b0, rd_pos}) : {1'b0, rd_pos};
    assign rd_hit  = ((rd_reg == REG_ORDER) && (rd_pos < ORDER_LEN)) ||
                     ((rd_reg == REG_FRAME) && (rd_pos < FRAME_LEN));
    assign rd_data = rd_hit ? store_reg[rd_addr[TX_IW-1:0]] : 8'd0;

endmodule

// ===== design/rsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsw_ctrl: register window control
// Register pointer, byte position and phase tracking; forms one result per beat.
// ----------------------------------------------------------------------------
module rsw_ctrl
    import rsw_pkg::*;
#(
    parameter int RX_BYTES    = RX_BYTES_DEF,
    parameter int ORDER_BYTES = ORDER_BYTES_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  item_t      item,
    input  logic [7:0] rx_rd_data,
    input  logic [7:0] tx_rd_data,
    output rx_wr_t     rx_wr,
    output tx_wr_t     tx_wr,
    output logic [7:0] tx_rd_reg,
    output logic [5:0] tx_rd_pos,
    output result_t    res
);

    localparam logic [5:0] RX_LEN    = 6'(RX_BYTES);
    localparam logic [5:0] ORDER_LEN = 6'(ORDER_BYTES);
    localparam logic [5:0] FRAME_LEN = 6'(FRAME_BYTES);

    logic [7:0] ptr_reg, ptr_next;
    logic [5:0] pos_reg, pos_next;
    logic       expect_reg, expect_next;
    logic [5:0] reg_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= 8'd0;
            pos_reg    <= 6'd0;
            expect_reg <= 1'b0;
        end
        else if (fire)
        begin
            ptr_reg    <= ptr_next;
            pos_reg    <= pos_next;
            expect_reg <= expect_next;
        end
    end

    // An unknown register reads as a single zero byte.
    always_comb
    begin
        if (ptr_reg == REG_ORDER)
        begin
            reg_len = ORDER_LEN;
        end
        else if (ptr_reg == REG_FRAME)
        begin
            reg_len = FRAME_LEN;
        end
        else
        begin
            reg_len = 6'd1;
        end
    end

    assign tx_rd_reg = ptr_reg;
    assign tx_rd_pos = item.is_data ? pos_reg : 6'd0;

    assign tx_wr.en    = fire && (item.mode == MODE_TX_WRITE);
    assign tx_wr.index = item.local_index;
    assign tx_wr.data  = item.local_value;

    always_comb
    begin
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        expect_next = expect_reg;
        rx_wr.en    = 1'b0;
        rx_wr.pos   = pos_reg;
        rx_wr.data  = item.bus_byte;
        res.send_byte       = 8'd0;
        res.send_valid      = 1'b0;
        res.stored          = 1'b0;
        res.local_read_byte = 8'd0;

        unique case (item.mode)
            MODE_TX_WRITE:
            begin
            end
            MODE_RX_READ:
            begin
                res.local_read_byte = rx_rd_data;
            end
            MODE_BUS_BYTE:
            begin
                if (item.is_read)
                begin
                    if (!item.is_data)
                    begin
                        res.send_byte  = tx_rd_data;
                        res.send_valid = 1'b1;
                        pos_next       = 6'd1;
                    end
                    else if (pos_reg < reg_len)
                    begin
                        res.send_byte  = tx_rd_data;
                        res.send_valid = 1'b1;
                        pos_next       = pos_reg + 6'd1;
                    end
                end
                else
                begin
                    if (!item.is_data)
                    begin
                        expect_next = 1'b1;
                    end
                    else if (expect_reg)
                    begin
                        ptr_next    = item.bus_byte;
                        pos_next    = 6'd0;
                        expect_next = 1'b0;
                    end
                    else if ((ptr_reg == REG_ORDER) && (pos_reg < RX_LEN))
                    begin
                        rx_wr.en   = fire;
                        pos_next   = pos_reg + 6'd1;
                        res.stored = 1'b1;
                    end
                end
            end
            MODE_COLLISION:
            begin
            end
            default:
            begin
            end
        endcase

        res.selected_register = ptr_next;
    end

endmodule

// ===== design/i2c_slave_register_window_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_register_window_unit: I2C slave register window
// Maps byte events of an I2C slave onto a receive store and two transmit
// registers, with local access to both stores.
// ----------------------------------------------------------------------------
// Usage:
// The slave side (s_*) takes one beat per event: local transmit-store write,
// local receive-store read, bus byte event or bus collision, chosen by the
// mode bits in s_tuser. The master side (m_*) returns exactly one result beat
// for every accepted beat, in order: the byte to send with its valid flag,
// the stored flag, the register pointer and the locally read byte.
// A beat is held in the input register and is then processed in a single
// step into the output register, which presents its result on m_* until it
// is taken. Throughput is one beat per cycle while m_tready stays high, set
// by that single processing stage, which both reads and updates the window
// state.
// Reset clears the pointer, byte position and phase, fills the receive store
// with 6 and the transmit store with zero; no clearing pass is needed.
// When m_tready is low the result holds, one more beat can still enter the
// input register, and s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_slave_register_window_unit
    import rsw_pkg::*;
#(
    parameter int RX_BYTES    = RX_BYTES_DEF,
    parameter int ORDER_BYTES = ORDER_BYTES_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bus_byte[7:0], local_index[12:8], local_value[20:13], zero[23:21]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[1:0], is_read[2], is_data[3]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // send_byte[7:0], selected_register[15:8], local_read_byte[23:16]
    output logic [M_TDATA_W-1:0] m_tdata,
    // send_valid[0], stored[1]
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    logic       advance;
    logic       fire;
    item_t      beat_item;
    result_t    res;
    rx_wr_t     rx_wr;
    tx_wr_t     tx_wr;
    logic [7:0] rx_rd_data;
    logic [7:0] tx_rd_data;
    logic [7:0] tx_rd_reg;
    logic [5:0] tx_rd_pos;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign beat_item.mode        = mode_t'(s_tuser[1:0]);
    assign beat_item.is_read     = s_tuser[2];
    assign beat_item.is_data     = s_tuser[3];
    assign beat_item.bus_byte    = s_tdata[7:0];
    assign beat_item.local_index = s_tdata[12:8];
    assign beat_item.local_value = s_tdata[20:13];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= beat_item;
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    rsw_ctrl #(
        .RX_BYTES    (RX_BYTES),
        .ORDER_BYTES (ORDER_BYTES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_item_reg),
        .rx_rd_data (rx_rd_data),
        .tx_rd_data (tx_rd_data),
        .rx_wr      (rx_wr),
        .tx_wr      (tx_wr),
        .tx_rd_reg  (tx_rd_reg),
        .tx_rd_pos  (tx_rd_pos),
        .res        (res)
    );

    rsw_rx_store #(
        .RX_BYTES (RX_BYTES)
    ) u_rx_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (rx_wr),
        .rd_index (in_item_reg.local_index),
        .rd_data  (rx_rd_data)
    );

    rsw_tx_store #(
        .ORDER_BYTES (ORDER_BYTES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_tx_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tx_wr),
        .rd_reg  (tx_rd_reg),
        .rd_pos  (tx_rd_pos),
        .rd_data (tx_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.local_read_byte, out_res_reg.selected_register,
                       out_res_reg.send_byte};
    assign m_tuser  = {out_res_reg.stored, out_res_reg.send_valid};

endmodule
